@@ src/pqsi_pkg.sv @@
// Package for the sorted priority queue: sizes, entry type and operation codes.
// No dependencies.
`timescale 1ns / 1ps

package pqsi_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 8;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [VAL_W-1:0]  val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ src/pqsi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pqsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/priority_queue_sorted_insert_top.sv @@
// Sorted priority queue top level; uses pqsi_pkg and pqsi_ram.
// Steps: insert scans from the tail and shifts lower-priority entries up one slot; remove of n >= 2
// entries shifts them down one slot; insert when full, remove when empty or with one entry go to finish.
// Throughput: one transaction at a time, set by the single RAM port pair moving one entry
// per cycle; the next input is taken the cycle after the result register loads.
// Reset: clears the entry count and control; entry storage is not cleared.
`timescale 1ns / 1ps

module priority_queue_sorted_insert_top
  import pqsi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  logic [PRIO_W-1:0]        priority_req,
  input  logic signed [VAL_W-1:0]  value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  head_value,
  output logic                     empty_res,
  output logic [COUNT_W-1:0]       count,
  output logic                     underflow,
  output logic                     overflow
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_CMP = 3'd1;
  localparam logic [2:0] ST_INS_PUT = 3'd2;
  localparam logic [2:0] ST_REM_SH  = 3'd3;
  localparam logic [2:0] ST_FIN     = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [VAL_W-1:0] head, head_next;
  entry_t           new_ent, new_ent_next;
  logic             under_f, under_f_next;
  logic             over_f, over_f_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             in_fire;
  logic             out_free;

  pqsi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    cur_next     = cur;
    head_next    = head;
    new_ent_next = new_ent;
    under_f_next = under_f;
    over_f_next  = over_f;
    ram_we       = 1'b0;
    ram_waddr    = cur;
    ram_wdata    = new_ent;
    ram_raddr    = cur;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          new_ent_next.prio = priority_req;
          new_ent_next.val  = value;
          under_f_next      = 1'b0;
          over_f_next       = 1'b0;
          if (func == FUNC_INSERT) begin
            if (fill >= CNT_W'(CAPACITY)) begin
              over_f_next = 1'b1;
              state_next  = ST_FIN;
            end else if (fill == '0) begin
              cur_next   = '0;
              state_next = ST_INS_PUT;
            end else begin
              ram_raddr  = IDX_W'(fill - 1'b1);
              cur_next   = IDX_W'(fill - 1'b1);
              state_next = ST_INS_CMP;
            end
          end else begin
            if (fill == '0) begin
              under_f_next = 1'b1;
              state_next   = ST_FIN;
            end else if (fill == CNT_W'(1)) begin
              fill_next  = '0;
              state_next = ST_FIN;
            end else begin
              ram_raddr  = IDX_W'(1);
              cur_next   = IDX_W'(1);
              state_next = ST_REM_SH;
            end
          end
        end
      end
      ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(cur + 1'b1);
        if (ram_rdata.prio >= new_ent.prio) begin
          ram_wdata  = new_ent;
          fill_next  = fill + 1'b1;
          state_next = ST_FIN;
        end else begin
          ram_wdata = ram_rdata;
          if (cur == '0) begin
            state_next = ST_INS_PUT;
          end else begin
            ram_raddr = cur - 1'b1;
            cur_next  = cur - 1'b1;
          end
        end
      end
      ST_INS_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = new_ent;
        head_next  = new_ent.val;
        fill_next  = fill + 1'b1;
        state_next = ST_FIN;
      end
      ST_REM_SH: begin
        ram_we    = 1'b1;
        ram_waddr = cur - 1'b1;
        ram_wdata = ram_rdata;
        if (cur == IDX_W'(1)) begin
          head_next = ram_rdata.val;
        end
        if (CNT_W'(cur) + 1'b1 == fill) begin
          fill_next  = fill - 1'b1;
          state_next = ST_FIN;
        end else begin
          ram_raddr = cur + 1'b1;
          cur_next  = cur + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    head    <= head_next;
    new_ent <= new_ent_next;
    under_f <= under_f_next;
    over_f  <= over_f_next;
    if (state == ST_FIN && out_free) begin
      head_value <= (fill == '0) ? '0 : head;
      empty_res  <= (fill == '0);
      count      <= COUNT_W'(fill);
      underflow  <= under_f;
      overflow   <= over_f;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(underflow && overflow))
    else $error("underflow and overflow both set");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (head_value == '0 && count == '0))
    else $error("empty result with nonzero head or count");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_CMP || state == ST_REM_SH) |-> (CNT_W'(cur) < fill))
    else $error("scan index outside held entries");

  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not loaded on finish");

endmodule
